// ===== design/bif_pkg.sv =====
package bif_pkg;

    localparam int WIDTH_MAX       = 64;
    localparam int HEIGHT_MAX      = 64;
    localparam int RADIUS_MAX      = 7;
    localparam int EXP_TABLE_DEPTH = 256;

    localparam int STORE_DEPTH = WIDTH_MAX * HEIGHT_MAX;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int PIX_W       = 48;
    localparam int CH_W        = 16;
    localparam int EXP_W       = 17;
    localparam int IDX_W       = $clog2(EXP_TABLE_DEPTH);
    localparam int IDXS_W      = IDX_W + 1;
    localparam int OPA_W       = 34;
    localparam int OPB_W       = 17;
    localparam int PROD_W      = OPA_W + OPB_W;
    localparam int SUM_W       = 41;
    localparam int TOT_W       = 25;
    localparam int DIV_W       = SUM_W + 1;
    localparam int Q_W         = 17;

    localparam logic [63:0] EXP_STEP_Q32 = 64'd4034748382;

    localparam logic [2:0] CFG_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_RADIUS = 3'd2;
    localparam logic [2:0] CFG_SSCALE = 3'd3;
    localparam logic [2:0] CFG_CSCALE = 3'd4;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef logic [EXP_W-1:0] t_exp_tab [EXP_TABLE_DEPTH];

    function automatic t_exp_tab f_build_exp();
        t_exp_tab    tab;
        logic [96:0] acc;
        acc = 97'(1) << 32;
        for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
            tab[i] = EXP_W'((acc + 97'd32768) >> 16);
            acc = (acc * 97'(EXP_STEP_Q32) + (97'(1) << 31)) >> 32;
        end
        return tab;
    endfunction

    localparam t_exp_tab EXP_TAB = f_build_exp();

    function automatic logic [EXP_W-1:0] f_exp(input logic [IDXS_W-1:0] idx);
        logic [EXP_W-1:0] v;
        if (idx >= IDXS_W'(EXP_TABLE_DEPTH)) begin
            v = '0;
        end else begin
            v = EXP_TAB[idx[IDX_W-1:0]];
        end
        return v;
    endfunction

endpackage

// ===== design/bilateral_image_filter.sv =====
// channel | direction | handshake               | payload
// in      | input     | i_in_valid / o_in_stall | req_type, pos_x, pos_y, red/green/blue_in
// out     | output    | o_out_valid / i_out_stall | red/green/blue_out, out_of_range
// cfg     | input     | i_cfg_we                | i_cfg_idx, i_cfg_data
// A load writes the frame store when accepted. A query in the frame first reads its centre,
// then scans the window: it skips each position outside the frame and runs a 12-step sequence
// on one shared 34x17 multiplier for each inside; then it does restoring division for each
// channel and hands over the result. An out-of-frame query goes straight to the hand-over.
// Synchronous reset clears control state, presets config; the frame store is not cleared.
// A pending result stalls only the hand-over step; o_in_stall is low whenever the sequencer idles.
module bilateral_image_filter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_req_type,
    input  logic [5:0]  i_pos_x,
    input  logic [5:0]  i_pos_y,
    input  logic [15:0] i_red_in,
    input  logic [15:0] i_green_in,
    input  logic [15:0] i_blue_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_red_out,
    output logic [15:0] o_green_out,
    output logic [15:0] o_blue_out,
    output logic        o_out_of_range,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_CTR  = 6'b000010,
        S_SCAN = 6'b000100,
        S_MUL  = 6'b001000,
        S_DIV  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state r_state;

    logic [6:0]  r_width, r_height;
    logic [2:0]  r_radius;
    logic [15:0] r_sscale, r_cscale;

    logic [5:0]  r_x, r_y;
    logic signed [4:0] r_dx, r_dy;
    logic [3:0]  r_step;
    logic [bif_pkg::CH_W-1:0] r_ctr [3];
    logic [7:0]  r_d2;
    logic [bif_pkg::OPA_W-1:0] r_c2;
    logic [bif_pkg::IDXS_W-1:0] r_sidx, r_cidx;
    logic [bif_pkg::EXP_W-1:0] r_ts, r_tc, r_wt;
    logic [bif_pkg::SUM_W-1:0] r_sum [3];
    logic [bif_pkg::TOT_W-1:0] r_total;
    logic [bif_pkg::DIV_W-1:0] r_rem, r_dsh;
    logic [bif_pkg::Q_W-1:0] r_q;
    logic [4:0]  r_bit;
    logic [1:0]  r_ch;
    logic [bif_pkg::CH_W-1:0] r_res [3];
    logic        r_oor;

    logic        r_out_valid;
    logic [15:0] r_red_out, r_green_out, r_blue_out;
    logic        r_out_of_range;

    logic [6:0]  w_eff, h_eff;
    logic [2:0]  rad_eff;
    logic        accept, in_frame_in;
    logic signed [7:0] nx, ny;
    logic        nb_in;
    logic [bif_pkg::ADDR_W-1:0] in_addr, nb_addr;
    logic        ram_we, ram_re;
    logic [bif_pkg::ADDR_W-1:0] ram_raddr;
    logic [bif_pkg::PIX_W-1:0] rdata;
    logic [bif_pkg::CH_W-1:0] nb [3];
    logic [bif_pkg::CH_W-1:0] diff [3];
    logic [2:0]  adx, ady;
    logic [bif_pkg::OPA_W-1:0] opa;
    logic [bif_pkg::OPB_W-1:0] opb;
    logic [bif_pkg::PROD_W-1:0] prod;
    logic [bif_pkg::IDXS_W-1:0] sidx_n, cidx_n;
    logic        last_x, last_y;
    logic [bif_pkg::DIV_W-1:0] first_rem;
    logic        sub_ok;
    logic [bif_pkg::Q_W-1:0] q_n;

    assign w_eff   = (r_width  > 7'(bif_pkg::WIDTH_MAX))  ? 7'(bif_pkg::WIDTH_MAX)  : r_width;
    assign h_eff   = (r_height > 7'(bif_pkg::HEIGHT_MAX)) ? 7'(bif_pkg::HEIGHT_MAX) : r_height;
    assign rad_eff = (r_radius > 3'(bif_pkg::RADIUS_MAX)) ? 3'(bif_pkg::RADIUS_MAX) : r_radius;

    assign o_in_stall  = (r_state != S_IDLE);
    assign accept      = i_in_valid && !o_in_stall;
    assign in_frame_in = ({1'b0, i_pos_x} < w_eff) && ({1'b0, i_pos_y} < h_eff);
    assign in_addr     = bif_pkg::ADDR_W'(i_pos_y) * bif_pkg::ADDR_W'(bif_pkg::WIDTH_MAX)
                       + bif_pkg::ADDR_W'(i_pos_x);

    assign nx    = $signed({2'b00, r_x}) + 8'(r_dx);
    assign ny    = $signed({2'b00, r_y}) + 8'(r_dy);
    assign nb_in = (nx >= 0) && (nx < $signed({1'b0, w_eff}))
                && (ny >= 0) && (ny < $signed({1'b0, h_eff}));
    assign nb_addr = bif_pkg::ADDR_W'(ny[5:0]) * bif_pkg::ADDR_W'(bif_pkg::WIDTH_MAX)
                   + bif_pkg::ADDR_W'(nx[5:0]);

    assign ram_we    = accept && (i_req_type == bif_pkg::REQ_LOAD) && in_frame_in;
    assign ram_re    = (accept && (i_req_type == bif_pkg::REQ_QUERY))
                    || ((r_state == S_SCAN) && nb_in);
    assign ram_raddr = (r_state == S_IDLE) ? in_addr : nb_addr;

    bif_ram #(
        .WIDTH(bif_pkg::PIX_W),
        .DEPTH(bif_pkg::STORE_DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(in_addr),
        .i_wdata({i_blue_in, i_green_in, i_red_in}),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(rdata)
    );

    assign nb[0] = rdata[15:0];
    assign nb[1] = rdata[31:16];
    assign nb[2] = rdata[47:32];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            diff[c] = (nb[c] >= r_ctr[c]) ? nb[c] - r_ctr[c] : r_ctr[c] - nb[c];
        end
    end

    assign adx = (r_dx < 0) ? 3'(-r_dx) : 3'(r_dx);
    assign ady = (r_dy < 0) ? 3'(-r_dy) : 3'(r_dy);

    always_comb begin
        unique case (r_step)
            4'd0:    begin opa = bif_pkg::OPA_W'(adx);     opb = bif_pkg::OPB_W'(adx);      end
            4'd1:    begin opa = bif_pkg::OPA_W'(ady);     opb = bif_pkg::OPB_W'(ady);      end
            4'd2:    begin opa = bif_pkg::OPA_W'(r_d2);    opb = bif_pkg::OPB_W'(r_sscale); end
            4'd3:    begin opa = bif_pkg::OPA_W'(diff[0]); opb = bif_pkg::OPB_W'(diff[0]);  end
            4'd4:    begin opa = bif_pkg::OPA_W'(diff[1]); opb = bif_pkg::OPB_W'(diff[1]);  end
            4'd5:    begin opa = bif_pkg::OPA_W'(diff[2]); opb = bif_pkg::OPB_W'(diff[2]);  end
            4'd6:    begin opa = r_c2;                     opb = bif_pkg::OPB_W'(r_cscale); end
            4'd8:    begin opa = bif_pkg::OPA_W'(r_ts);    opb = r_tc;                      end
            4'd9:    begin opa = bif_pkg::OPA_W'(nb[0]);   opb = r_wt;                      end
            4'd10:   begin opa = bif_pkg::OPA_W'(nb[1]);   opb = r_wt;                      end
            4'd11:   begin opa = bif_pkg::OPA_W'(nb[2]);   opb = r_wt;                      end
            default: begin opa = '0;                       opb = '0;                        end
        endcase
    end

    assign prod = bif_pkg::PROD_W'(opa) * bif_pkg::PROD_W'(opb);

    assign sidx_n = (prod[bif_pkg::PROD_W-1:4] >= (bif_pkg::PROD_W-4)'(bif_pkg::EXP_TABLE_DEPTH))
                  ? bif_pkg::IDXS_W'(bif_pkg::EXP_TABLE_DEPTH)
                  : bif_pkg::IDXS_W'(prod[bif_pkg::PROD_W-1:4]);
    assign cidx_n = (prod[bif_pkg::PROD_W-1:28] >= (bif_pkg::PROD_W-28)'(bif_pkg::EXP_TABLE_DEPTH))
                  ? bif_pkg::IDXS_W'(bif_pkg::EXP_TABLE_DEPTH)
                  : bif_pkg::IDXS_W'(prod[bif_pkg::PROD_W-1:28]);

    assign last_x = (r_dx == $signed({2'b00, rad_eff}));
    assign last_y = (r_dy == $signed({2'b00, rad_eff}));

    assign first_rem = bif_pkg::DIV_W'(r_sum[0]) + bif_pkg::DIV_W'(r_total >> 1);
    assign sub_ok    = (r_rem >= r_dsh);
    assign q_n       = {r_q[bif_pkg::Q_W-2:0], sub_ok};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 7'd64;
            r_height <= 7'd64;
            r_radius <= 3'd2;
            r_sscale <= 16'd256;
            r_cscale <= 16'd256;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bif_pkg::CFG_WIDTH:  r_width  <= i_cfg_data[6:0];
                bif_pkg::CFG_HEIGHT: r_height <= i_cfg_data[6:0];
                bif_pkg::CFG_RADIUS: r_radius <= i_cfg_data[2:0];
                bif_pkg::CFG_SSCALE: r_sscale <= i_cfg_data;
                bif_pkg::CFG_CSCALE: r_cscale <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_step      <= '0;
        end else begin
            if (r_state == S_OUT && (!r_out_valid || !i_out_stall)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept && (i_req_type == bif_pkg::REQ_QUERY)) begin
                        r_x <= i_pos_x;
                        r_y <= i_pos_y;
                        if (in_frame_in) begin
                            r_oor   <= 1'b0;
                            r_state <= S_CTR;
                        end else begin
                            r_oor    <= 1'b1;
                            r_res[0] <= '0;
                            r_res[1] <= '0;
                            r_res[2] <= '0;
                            r_state  <= S_OUT;
                        end
                    end
                end
                S_CTR: begin
                    r_ctr[0] <= nb[0];
                    r_ctr[1] <= nb[1];
                    r_ctr[2] <= nb[2];
                    r_dx     <= -$signed({2'b00, rad_eff});
                    r_dy     <= -$signed({2'b00, rad_eff});
                    r_sum[0] <= '0;
                    r_sum[1] <= '0;
                    r_sum[2] <= '0;
                    r_total  <= '0;
                    r_state  <= S_SCAN;
                end
                S_SCAN, S_MUL: begin
                    if (r_state == S_SCAN && nb_in) begin
                        r_step  <= '0;
                        r_state <= S_MUL;
                    end else if (r_state == S_MUL && r_step != 4'd11) begin
                        r_step <= r_step + 4'd1;
                        unique case (r_step)
                            4'd0: r_d2 <= 8'(prod);
                            4'd1: r_d2 <= r_d2 + 8'(prod);
                            4'd2: r_sidx <= sidx_n;
                            4'd3: begin
                                r_c2 <= bif_pkg::OPA_W'(prod);
                                r_ts <= bif_pkg::f_exp(r_sidx);
                            end
                            4'd4, 4'd5: r_c2 <= r_c2 + bif_pkg::OPA_W'(prod);
                            4'd6: r_cidx <= cidx_n;
                            4'd7: r_tc <= bif_pkg::f_exp(r_cidx);
                            4'd8: r_wt <= bif_pkg::EXP_W'((prod + 51'd32768) >> 16);
                            4'd9: begin
                                r_sum[0] <= r_sum[0] + bif_pkg::SUM_W'(prod);
                                r_total  <= r_total + bif_pkg::TOT_W'(r_wt);
                            end
                            4'd10: r_sum[1] <= r_sum[1] + bif_pkg::SUM_W'(prod);
                            default: ;
                        endcase
                    end else begin
                        if (r_state == S_MUL) begin
                            r_sum[2] <= r_sum[2] + bif_pkg::SUM_W'(prod);
                        end
                        if (last_x) begin
                            r_dx <= -$signed({2'b00, rad_eff});
                        end else begin
                            r_dx <= r_dx + 5'sd1;
                        end
                        if (last_x && last_y) begin
                            r_state <= S_DIV;
                            r_ch    <= 2'd0;
                            r_bit   <= 5'd16;
                            r_q     <= '0;
                            r_dsh   <= {1'b0, r_total, 16'b0};
                            r_rem   <= first_rem;
                        end else begin
                            r_state <= S_SCAN;
                            if (last_x) begin
                                r_dy <= r_dy + 5'sd1;
                            end
                        end
                    end
                end
                S_DIV: begin
                    if (r_bit == 5'd0) begin
                        r_res[r_ch] <= q_n[bif_pkg::Q_W-1] ? 16'hFFFF : q_n[15:0];
                        r_bit <= 5'd16;
                        r_q   <= '0;
                        r_dsh <= {1'b0, r_total, 16'b0};
                        r_rem <= bif_pkg::DIV_W'(r_sum[(r_ch == 2'd0) ? 1 : 2])
                               + bif_pkg::DIV_W'(r_total >> 1);
                        if (r_ch == 2'd2) begin
                            r_state <= S_OUT;
                        end else begin
                            r_ch <= r_ch + 2'd1;
                        end
                    end else begin
                        if (sub_ok) begin
                            r_rem <= r_rem - r_dsh;
                        end
                        r_q   <= q_n;
                        r_dsh <= r_dsh >> 1;
                        r_bit <= r_bit - 5'd1;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_red_out      <= r_res[0];
                        r_green_out    <= r_res[1];
                        r_blue_out     <= r_res[2];
                        r_out_of_range <= r_oor;
                        r_step         <= '0;
                        r_state        <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_red_out      = r_red_out;
    assign o_green_out    = r_green_out;
    assign o_blue_out     = r_blue_out;
    assign o_out_of_range = r_out_of_range;

endmodule

// ===== design/bif_ram.sv =====
module bif_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/bif_checker.sv =====
module bif_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        i_req_type,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [15:0] o_red_out,
    input logic [15:0] o_green_out,
    input logic [15:0] o_blue_out,
    input logic        o_out_of_range
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_red_out) && $stable(o_green_out)
            && $stable(o_blue_out) && $stable(o_out_of_range))
        else $error("stalled result changed");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_req_type |=> o_in_stall)
        else $error("query did not occupy the sequencer");

    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_of_range |-> o_red_out == 16'd0 && o_green_out == 16'd0
            && o_blue_out == 16'd0)
        else $error("out-of-range result carries color");

    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && !i_req_type |=> !$rose(o_out_valid))
        else $error("load produced a result");

endmodule

bind bilateral_image_filter bif_checker u_bif_checker (.*);

// ===== sim/bilateral_image_filter_test.sv =====
`timescale 1ns / 1ps

module bilateral_image_filter_test;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 10;
    localparam int PHASE_ITEMS    = 150;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic        out_of_range;
    } t_filtered_pixel;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_req_type;
    logic [5:0]  i_pos_x;
    logic [5:0]  i_pos_y;
    logic [15:0] i_red_in;
    logic [15:0] i_green_in;
    logic [15:0] i_blue_in;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [15:0] o_red_out;
    logic [15:0] o_green_out;
    logic [15:0] o_blue_out;
    logic        o_out_of_range;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;

    bilateral_image_filter dut (.*);

    // predictor state
    logic [15:0]     pixel_mem [bif_pkg::STORE_DEPTH][3];
    bit              pixel_loaded [bif_pkg::STORE_DEPTH];
    logic [16:0]     decay_table [bif_pkg::EXP_TABLE_DEPTH];
    logic [6:0]      cfg_width;
    logic [6:0]      cfg_height;
    logic [2:0]      cfg_radius;
    logic [15:0]     cfg_spatial;
    logic [15:0]     cfg_color;
    t_filtered_pixel pending_pixels [$];

    int idle_pct;
    int stall_pct;
    int mismatch_count;
    int result_count;
    int load_count;
    int query_count;
    int cfg_count;
    int quiet_cycles;
    bit running;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void build_decay_table();
        logic [95:0] acc;
        acc = 96'd1 << 32;
        for (int i = 0; i < bif_pkg::EXP_TABLE_DEPTH; i++) begin
            decay_table[i] = 17'((acc + 96'd32768) >> 16);
            acc = (acc * 96'd4034748382 + (96'd1 << 31)) >> 32;
        end
    endfunction

    function automatic logic [63:0] decay(input logic [63:0] idx);
        return (idx >= bif_pkg::EXP_TABLE_DEPTH) ? 64'd0 : 64'(decay_table[idx]);
    endfunction

    function automatic int frame_w();
        return (cfg_width > bif_pkg::WIDTH_MAX) ? bif_pkg::WIDTH_MAX : int'(cfg_width);
    endfunction

    function automatic int frame_h();
        return (cfg_height > bif_pkg::HEIGHT_MAX) ? bif_pkg::HEIGHT_MAX : int'(cfg_height);
    endfunction

    function automatic int window_radius();
        return (cfg_radius > bif_pkg::RADIUS_MAX) ? bif_pkg::RADIUS_MAX : int'(cfg_radius);
    endfunction

    function automatic bit in_frame(input int x, input int y);
        return x >= 0 && y >= 0 && x < frame_w() && y < frame_h();
    endfunction

    function automatic t_filtered_pixel filter_at(input int x, input int y);
        t_filtered_pixel res;
        logic [63:0]     acc [3];
        logic [63:0]     total;
        logic [63:0]     c2;
        logic [63:0]     wt;
        logic [63:0]     ts;
        logic [63:0]     tc;
        logic [63:0]     v;
        int              r;
        int              ca;
        int              na;
        int              diff;
        res = '0;
        if (!in_frame(x, y)) begin
            res.out_of_range = 1'b1;
            return res;
        end
        r = window_radius();
        ca = y * bif_pkg::WIDTH_MAX + x;
        total = 0;
        for (int c = 0; c < 3; c++) acc[c] = 0;
        for (int dy = -r; dy <= r; dy++) begin
            for (int dx = -r; dx <= r; dx++) begin
                if (!in_frame(x + dx, y + dy)) continue;
                na = (y + dy) * bif_pkg::WIDTH_MAX + x + dx;
                ts = decay((64'(dx * dx + dy * dy) * cfg_spatial) >> 4);
                c2 = 0;
                for (int c = 0; c < 3; c++) begin
                    diff = int'(pixel_mem[na][c]) - int'(pixel_mem[ca][c]);
                    if (diff < 0) diff = -diff;
                    c2 += 64'(diff) * 64'(diff);
                end
                tc = decay((c2 * cfg_color) >> 28);
                wt = (ts * tc + 64'd32768) >> 16;
                for (int c = 0; c < 3; c++) acc[c] += wt * pixel_mem[na][c];
                total += wt;
            end
        end
        for (int c = 0; c < 3; c++) begin
            v = (acc[c] + total / 2) / total;
            if (v > 64'hFFFF) v = 64'hFFFF;
            if (c == 0) res.red = v[15:0];
            else if (c == 1) res.green = v[15:0];
            else res.blue = v[15:0];
        end
        return res;
    endfunction

    task automatic send_item(input logic rt, input logic [5:0] x, input logic [5:0] y,
                             input logic [15:0] r, input logic [15:0] g,
                             input logic [15:0] b);
        int a;
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= rt;
        i_pos_x    <= x;
        i_pos_y    <= y;
        i_red_in   <= r;
        i_green_in <= g;
        i_blue_in  <= b;
        do @(posedge i_clk); while (o_in_stall);
        if (rt == bif_pkg::REQ_LOAD) begin
            load_count++;
            if (in_frame(x, y)) begin
                a = int'(y) * bif_pkg::WIDTH_MAX + int'(x);
                pixel_mem[a][0] = r;
                pixel_mem[a][1] = g;
                pixel_mem[a][2] = b;
                pixel_loaded[a] = 1'b1;
            end
        end else begin
            query_count++;
            pending_pixels.push_back(filter_at(x, y));
        end
    endtask

    // load every in-frame pixel of the window that has never been written, then send the query
    task automatic query_pixel(input int x, input int y);
        int r;
        r = window_radius();
        if (in_frame(x, y)) begin
            for (int dy = -r; dy <= r; dy++) begin
                for (int dx = -r; dx <= r; dx++) begin
                    if (in_frame(x + dx, y + dy) &&
                        !pixel_loaded[(y + dy) * bif_pkg::WIDTH_MAX + x + dx]) begin
                        send_item(bif_pkg::REQ_LOAD, 6'(x + dx), 6'(y + dy), 16'($urandom),
                                  16'($urandom), 16'($urandom));
                    end
                end
            end
        end
        send_item(bif_pkg::REQ_QUERY, 6'(x), 6'(y), 16'($urandom), 16'($urandom),
                  16'($urandom));
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
        i_in_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_count++;
        case (idx)
            bif_pkg::CFG_WIDTH:  cfg_width   = value[6:0];
            bif_pkg::CFG_HEIGHT: cfg_height  = value[6:0];
            bif_pkg::CFG_RADIUS: cfg_radius  = value[2:0];
            bif_pkg::CFG_SSCALE: cfg_spatial = value;
            bif_pkg::CFG_CSCALE: cfg_color   = value;
            default: ;
        endcase
    endtask

    task automatic set_frame(input logic [15:0] w, input logic [15:0] h,
                             input logic [15:0] r, input logic [15:0] ss,
                             input logic [15:0] cs);
        write_reg(bif_pkg::CFG_WIDTH, w);
        write_reg(bif_pkg::CFG_HEIGHT, h);
        write_reg(bif_pkg::CFG_RADIUS, r);
        write_reg(bif_pkg::CFG_SSCALE, ss);
        write_reg(bif_pkg::CFG_CSCALE, cs);
    endtask

    task automatic test_reset_defaults();
        send_item(bif_pkg::REQ_LOAD, 6'd0, 6'd0, 16'h0000, 16'h0000, 16'h0000);
        send_item(bif_pkg::REQ_LOAD, 6'd1, 6'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        query_pixel(0, 0);
        query_pixel(63, 63);
        send_item(bif_pkg::REQ_LOAD, 6'd62, 6'd63, 16'hFFFF, 16'h0000, 16'hFFFF);
        query_pixel(63, 63);
        query_pixel(32, 17);
    endtask

    task automatic test_register_extremes();
        set_frame(16'd0, 16'd64, 16'd2, 16'd256, 16'd256);
        send_item(bif_pkg::REQ_LOAD, 6'd5, 6'd5, 16'h1234, 16'h5678, 16'h9ABC);
        query_pixel(0, 0);
        set_frame(16'h007F, 16'h0064, 16'd0, 16'd0, 16'd0);
        query_pixel(63, 0);
        set_frame(16'd4, 16'd3, 16'd7, 16'd0, 16'd0);
        query_pixel(1, 1);
        query_pixel(4, 0);
        query_pixel(0, 3);
        send_item(bif_pkg::REQ_LOAD, 6'd63, 6'd2, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        set_frame(16'd1, 16'd1, 16'd7, 16'hFFFF, 16'hFFFF);
        query_pixel(0, 0);
        set_frame(16'd8, 16'd8, 16'd3, 16'd16, 16'd1);
        query_pixel(3, 3);
        query_pixel(7, 7);
    endtask

    task automatic test_random_traffic(input int sender_idle, input int receiver_stall);
        int w;
        int h;
        int x;
        int y;
        int start;
        idle_pct  = sender_idle;
        stall_pct = receiver_stall;
        start     = load_count + query_count;
        while (load_count + query_count - start < PHASE_ITEMS) begin
            case ($urandom_range(7))
                0: w = 0;
                1: w = $urandom_range(65, 127);
                2: w = 64;
                default: w = $urandom_range(1, 24);
            endcase
            h = ($urandom_range(5) == 0) ? 64 : $urandom_range(1, 24);
            set_frame(16'(w), 16'(h),
                      16'(($urandom_range(7) == 0) ? 7 : $urandom_range(0, 3)),
                      16'(($urandom_range(5) == 0) ? $urandom : $urandom_range(0, 1024)),
                      16'(($urandom_range(5) == 0) ? $urandom : $urandom_range(0, 2048)));
            for (int n = 0; n < 40 && load_count + query_count - start < PHASE_ITEMS; n++) begin
                if ($urandom_range(99) < 70 && frame_w() > 0 && frame_h() > 0) begin
                    x = $urandom_range(frame_w() - 1);
                    y = $urandom_range(frame_h() - 1);
                end else begin
                    x = $urandom_range(63);
                    y = $urandom_range(63);
                end
                if ($urandom_range(99) < 40) begin
                    send_item(bif_pkg::REQ_LOAD, 6'(x), 6'(y), 16'($urandom), 16'($urandom),
                              16'($urandom));
                end else begin
                    query_pixel(x, y);
                end
            end
        end
        i_in_valid <= 1'b0;
    endtask

    initial begin
        build_decay_table();
        cfg_width   = 7'd64;
        cfg_height  = 7'd64;
        cfg_radius  = 3'd2;
        cfg_spatial = 16'd256;
        cfg_color   = 16'd256;
        idle_pct    = 0;
        stall_pct   = 0;
        running     = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_req_type  = bif_pkg::REQ_LOAD;
        i_pos_x     = '0;
        i_pos_y     = '0;
        i_red_in    = '0;
        i_green_in  = '0;
        i_blue_in   = '0;
        i_out_stall = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = bif_pkg::CFG_WIDTH;
        i_cfg_data  = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        running = 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_register_extremes();
        test_random_traffic(0, 0);
        test_random_traffic(75, 0);
        test_random_traffic(0, 75);
        test_random_traffic(9, 9);

        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Covered %0d loads and %0d queries, %0d results checked,", load_count,
                 query_count, result_count);
        $display("%0d register writes, %0d mismatches.", cfg_count, mismatch_count);
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        t_filtered_pixel want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            result_count++;
            if (pending_pixels.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) $display("Unexpected result transaction");
            end else begin
                want = pending_pixels.pop_front();
                if (o_red_out !== want.red || o_green_out !== want.green ||
                    o_blue_out !== want.blue || o_out_of_range !== want.out_of_range) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("Mismatch: exp rgb %h %h %h oor %b, got %h %h %h oor %b",
                                 want.red, want.green, want.blue, want.out_of_range,
                                 o_red_out, o_green_out, o_blue_out, o_out_of_range);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (running) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Timeout with %0d results outstanding", pending_pixels.size());
                $display("Simulation FAILED");
                $finish;
            end
        end else begin
            quiet_cycles <= 0;
        end
    end

endmodule

// ===== filelist.f =====
design/bif_pkg.sv
design/bif_ram.sv
design/bilateral_image_filter.sv
design/bif_checker.sv
sim/bilateral_image_filter_test.sv
